// ===== src/assert_macros.svh =====
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define AST_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, sampled on the rising clock, off during reset.
`define AST_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== src/lsr_pkg.sv =====
package lsr_pkg;

    // Width of the proximity range register.
    localparam int RANGE_BITS = 8;

    typedef logic [1:0] t_kind;

    // Region kinds reported with every result.
    localparam t_kind KIND_HORZ  = 2'd0;
    localparam t_kind KIND_VERT  = 2'd1;
    localparam t_kind KIND_SLANT = 2'd2;

endpackage

// ===== src/lsr_front.sv =====
module lsr_front import lsr_pkg::*; #(
    parameter int CB = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_vld,
    input  logic signed [CB-1:0]          i_sx,
    input  logic signed [CB-1:0]          i_sy,
    input  logic signed [CB-1:0]          i_ex,
    input  logic signed [CB-1:0]          i_ey,
    input  logic [RANGE_BITS-1:0]         i_range,
    output logic                          o_vld,
    output logic [6*CB+2:0]               o_side,
    output logic [2*(RANGE_BITS+CB)-1:0]  o_n,
    output logic [2*CB:0]                 o_d
);

    localparam int RB  = RANGE_BITS;
    localparam int RAW = RB + CB;

    logic signed [CB:0] dx, dy;
    logic [CB-1:0]      n_adx, n_ady;
    t_kind              n_kind;

    logic               r1_vld, r2_vld, r3_vld;
    logic [6*CB+2:0]    r1_side, r2_side, r3_side;
    logic [CB-1:0]      r1_adx, r1_ady;
    logic [RAW-1:0]     r2_ra;
    logic [2*CB-1:0]    r2_ax2, r2_ay2;
    logic [2*RAW-1:0]   r3_n;
    logic [2*CB:0]      r3_d;

    // Differences, magnitudes and the kind of region.
    always_comb begin
        dx = $signed({i_ex[CB-1], i_ex}) - $signed({i_sx[CB-1], i_sx});
        dy = $signed({i_ey[CB-1], i_ey}) - $signed({i_sy[CB-1], i_sy});
        n_adx = dx[CB] ? CB'(-dx) : dx[CB-1:0];
        n_ady = dy[CB] ? CB'(-dy) : dy[CB-1:0];
        if (i_sy == i_ey) begin
            n_kind = KIND_HORZ;
        end else if (i_sx == i_ex) begin
            n_kind = KIND_VERT;
        end else begin
            n_kind = KIND_SLANT;
        end
    end

    // Valid bits of the three front stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
        end else if (i_en) begin
            r1_vld <= i_vld;
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
        end
    end

    // Stage one registers the geometry, stage two the products, stage three the
    // squared numerator and the squared length.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_side <= {i_sx, i_sy, i_ex, i_ey, n_adx, n_ady, n_kind, dx[CB] ^ dy[CB]};
            r1_adx  <= n_adx;
            r1_ady  <= n_ady;
            r2_side <= r1_side;
            r2_ra   <= {{CB{1'b0}}, i_range} * {{RB{1'b0}}, r1_ady};
            r2_ax2  <= {{CB{1'b0}}, r1_adx} * {{CB{1'b0}}, r1_adx};
            r2_ay2  <= {{CB{1'b0}}, r1_ady} * {{CB{1'b0}}, r1_ady};
            r3_side <= r2_side;
            r3_n    <= {{RAW{1'b0}}, r2_ra} * {{RAW{1'b0}}, r2_ra};
            r3_d    <= {1'b0, r2_ax2} + {1'b0, r2_ay2};
        end
    end

    assign o_vld  = r3_vld;
    assign o_side = r3_side;
    assign o_n    = r3_n;
    assign o_d    = r3_d;

endmodule

// ===== src/lsr_div.sv =====
module lsr_div import lsr_pkg::*; #(
    parameter int W  = 33,
    parameter int QW = 48,
    parameter int SW = 99
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_vld,
    input  logic [W-1:0]  i_rem,
    input  logic [QW-1:0] i_bits,
    input  logic [W-1:0]  i_dvs,
    input  logic [SW-1:0] i_side,
    output logic          o_vld,
    output logic [QW-1:0] o_quo,
    output logic [SW-1:0] o_side
);

    // One quotient bit per stage, restoring long division.
    logic          r_vld  [QW];
    logic [W-1:0]  r_rem  [QW];
    logic [QW-1:0] r_bits [QW];
    logic [QW-1:0] r_quo  [QW];
    logic [W-1:0]  r_dvs  [QW];
    logic [SW-1:0] r_side [QW];

    logic          s_vld  [QW];
    logic [W-1:0]  s_rem  [QW];
    logic [QW-1:0] s_bits [QW];
    logic [QW-1:0] s_quo  [QW];
    logic [W-1:0]  s_dvs  [QW];
    logic [SW-1:0] s_side [QW];

    logic [W-1:0]  n_rem  [QW];
    logic [QW-1:0] n_quo  [QW];

    // Stage sources: the ports for the first stage, the previous stage otherwise.
    always_comb begin
        for (int k = 0; k < QW; k++) begin
            if (k == 0) begin
                s_vld[k]  = i_vld;
                s_rem[k]  = i_rem;
                s_bits[k] = i_bits;
                s_quo[k]  = '0;
                s_dvs[k]  = i_dvs;
                s_side[k] = i_side;
            end else begin
                s_vld[k]  = r_vld[k-1];
                s_rem[k]  = r_rem[k-1];
                s_bits[k] = r_bits[k-1];
                s_quo[k]  = r_quo[k-1];
                s_dvs[k]  = r_dvs[k-1];
                s_side[k] = r_side[k-1];
            end
        end
    end

    // Trial subtraction of every stage.
    always_comb begin
        logic [W:0] trial;
        logic       fits;
        for (int k = 0; k < QW; k++) begin
            trial    = {s_rem[k], s_bits[k][QW-1]};
            fits     = trial >= {1'b0, s_dvs[k]};
            n_rem[k] = fits ? W'(trial - {1'b0, s_dvs[k]}) : trial[W-1:0];
            n_quo[k] = {s_quo[k][QW-2:0], fits};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < QW; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else if (i_en) begin
            for (int k = 0; k < QW; k++) begin
                r_vld[k] <= s_vld[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < QW; k++) begin
                r_rem[k]  <= n_rem[k];
                r_bits[k] <= s_bits[k] << 1;
                r_quo[k]  <= n_quo[k];
                r_dvs[k]  <= s_dvs[k];
                r_side[k] <= s_side[k];
            end
        end
    end

    assign o_vld  = r_vld[QW-1];
    assign o_quo  = r_quo[QW-1];
    assign o_side = r_side[QW-1];

endmodule

// ===== src/lsr_sqrt.sv =====
module lsr_sqrt import lsr_pkg::*; #(
    parameter int XW = 48,
    parameter int SW = 99
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_vld,
    input  logic [XW-1:0]   i_x,
    input  logic [SW-1:0]   i_side,
    output logic            o_vld,
    output logic [XW/2-1:0] o_root,
    output logic [SW-1:0]   o_side
);

    localparam int RW = XW / 2;

    // One root bit per stage, two radicand bits consumed per stage.
    logic          r_vld  [RW];
    logic [RW+1:0] r_rem  [RW];
    logic [RW-1:0] r_root [RW];
    logic [XW-1:0] r_x    [RW];
    logic [SW-1:0] r_side [RW];

    logic          s_vld  [RW];
    logic [RW+1:0] s_rem  [RW];
    logic [RW-1:0] s_root [RW];
    logic [XW-1:0] s_x    [RW];
    logic [SW-1:0] s_side [RW];

    logic [RW+1:0] n_rem  [RW];
    logic [RW-1:0] n_root [RW];

    always_comb begin
        for (int k = 0; k < RW; k++) begin
            if (k == 0) begin
                s_vld[k]  = i_vld;
                s_rem[k]  = '0;
                s_root[k] = '0;
                s_x[k]    = i_x;
                s_side[k] = i_side;
            end else begin
                s_vld[k]  = r_vld[k-1];
                s_rem[k]  = r_rem[k-1];
                s_root[k] = r_root[k-1];
                s_x[k]    = r_x[k-1];
                s_side[k] = r_side[k-1];
            end
        end
    end

    // Trial subtraction of 4*root+1 from the shifted remainder.
    always_comb begin
        logic [RW+3:0] t;
        logic [RW+3:0] trial;
        logic          fits;
        for (int k = 0; k < RW; k++) begin
            t         = {s_rem[k], s_x[k][XW-1:XW-2]};
            trial     = {2'b00, s_root[k], 2'b01};
            fits      = t >= trial;
            n_rem[k]  = fits ? (RW+2)'(t - trial) : t[RW+1:0];
            n_root[k] = {s_root[k][RW-2:0], fits};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < RW; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else if (i_en) begin
            for (int k = 0; k < RW; k++) begin
                r_vld[k] <= s_vld[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < RW; k++) begin
                r_rem[k]  <= n_rem[k];
                r_root[k] <= n_root[k];
                r_x[k]    <= s_x[k] << 2;
                r_side[k] <= s_side[k];
            end
        end
    end

    assign o_vld  = r_vld[RW-1];
    assign o_root = r_root[RW-1];
    assign o_side = r_side[RW-1];

endmodule

// ===== src/lsr_back.sv =====
module lsr_back import lsr_pkg::*; #(
    parameter int CB = 16,
    parameter int FB = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  logic                   i_vld,
    input  logic [6*CB+2:0]        i_side,
    input  logic [RANGE_BITS:0]    i_oxu,
    input  logic [RANGE_BITS+FB-1:0] i_m,
    input  logic [RANGE_BITS-1:0]  i_range,
    output logic                   o_vld,
    output logic [1:0]             o_kind,
    output logic signed [CB:0]     o_c0x,
    output logic signed [CB:0]     o_c0y,
    output logic signed [CB:0]     o_c1x,
    output logic signed [CB:0]     o_c1y,
    output logic signed [CB:0]     o_c2x,
    output logic signed [CB:0]     o_c2y,
    output logic signed [CB:0]     o_c3x,
    output logic signed [CB:0]     o_c3y
);

    localparam int RB = RANGE_BITS;
    localparam int MW = RB + FB;
    localparam int E  = CB + 2;

    logic signed [CB-1:0] sx, sy, ex, ey;
    t_kind                kind;
    logic                 neg;

    logic signed [E-1:0]  sx_e, sy_e, ex_e, ey_e, r_e, ox_e, oy_e, lo_e, hi_e;
    logic [MW:0]          m_rnd;
    logic [RB:0]          oyu;
    logic signed [E-1:0]  n_c [8];

    logic                 r_vld;
    t_kind                r_kind;
    logic signed [CB:0]   r_c [8];

    // Endpoints, kind and sign from the side band; the magnitudes are not needed here.
    assign {sx, sy, ex, ey} = i_side[6*CB+2:2*CB+3];
    assign kind             = i_side[2:1];
    assign neg              = i_side[0];

    // Rounded offsets and the corners for each kind of region.
    always_comb begin
        sx_e  = E'(sx);
        sy_e  = E'(sy);
        ex_e  = E'(ex);
        ey_e  = E'(ey);
        r_e   = $signed({{(E-RB){1'b0}}, i_range});
        ox_e  = $signed({{(E-RB-1){1'b0}}, i_oxu});
        m_rnd = {1'b0, i_m} + ((MW+1)'(1) << (FB-1));
        oyu   = m_rnd[MW:FB];
        oy_e  = neg ? $signed({{(E-RB-1){1'b0}}, oyu})
                    : -$signed({{(E-RB-1){1'b0}}, oyu});
        lo_e  = '0;
        hi_e  = '0;
        for (int k = 0; k < 8; k++) begin
            n_c[k] = '0;
        end
        case (kind)
            KIND_HORZ: begin
                lo_e   = (sx_e < ex_e) ? sx_e : ex_e;
                hi_e   = (sx_e < ex_e) ? ex_e : sx_e;
                n_c[0] = lo_e;             n_c[1] = sy_e - r_e;
                n_c[2] = hi_e;             n_c[3] = sy_e - r_e;
                n_c[4] = hi_e;             n_c[5] = sy_e + r_e + E'(1);
                n_c[6] = lo_e;             n_c[7] = sy_e + r_e + E'(1);
            end
            KIND_VERT: begin
                lo_e   = (sy_e < ey_e) ? sy_e : ey_e;
                hi_e   = (sy_e < ey_e) ? ey_e : sy_e;
                n_c[0] = sx_e - r_e;          n_c[1] = lo_e;
                n_c[2] = sx_e + r_e + E'(1);  n_c[3] = lo_e;
                n_c[4] = sx_e + r_e + E'(1);  n_c[5] = hi_e;
                n_c[6] = sx_e - r_e;          n_c[7] = hi_e;
            end
            default: begin
                n_c[0] = sx_e + ox_e;  n_c[1] = sy_e + oy_e;
                n_c[2] = sx_e - ox_e;  n_c[3] = sy_e - oy_e;
                n_c[4] = ex_e - ox_e;  n_c[5] = ey_e - oy_e;
                n_c[6] = ex_e + ox_e;  n_c[7] = ey_e + oy_e;
            end
        endcase
    end

    // Output register: holds the result while the consumer stalls.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_kind <= kind;
            for (int k = 0; k < 8; k++) begin
                r_c[k] <= n_c[k][CB:0];
            end
        end
    end

    assign o_vld  = r_vld;
    assign o_kind = r_kind;
    assign o_c0x  = r_c[0];
    assign o_c0y  = r_c[1];
    assign o_c1x  = r_c[2];
    assign o_c1y  = r_c[3];
    assign o_c2x  = r_c[4];
    assign o_c2y  = r_c[5];
    assign o_c3x  = r_c[6];
    assign o_c3y  = r_c[7];

endmodule

// ===== src/line_selection_region.sv =====
// Channel   Direction  Handshake           Payload
// input     in         i_valid / o_stall   i_start_x, i_start_y, i_end_x, i_end_y
// result    out        o_valid / i_stall   o_region_kind, o_corner0..3_x/_y
// config    in         i_cfg_we            i_cfg_data (proximity range)
//
// One segment can enter every cycle unless a stalled result holds the pipeline. The stages
// are 3 front stages, 2*(8+FRAC_BITS) length divider stages, 8+FRAC_BITS root
// stages, 1 product stage, 8+FRAC_BITS slope divider stages and 1 output stage.
// Synchronous active-low reset clears the valid bits and sets the range to 4.
// A stalled result holds the whole pipeline in place; nothing is dropped or repeated.
module line_selection_region import lsr_pkg::*; #(
    parameter int COORD_BITS = 16,
    parameter int FRAC_BITS  = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic signed [COORD_BITS-1:0] i_start_x,
    input  logic signed [COORD_BITS-1:0] i_start_y,
    input  logic signed [COORD_BITS-1:0] i_end_x,
    input  logic signed [COORD_BITS-1:0] i_end_y,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [1:0]                  o_region_kind,
    output logic signed [COORD_BITS:0]  o_corner0_x,
    output logic signed [COORD_BITS:0]  o_corner0_y,
    output logic signed [COORD_BITS:0]  o_corner1_x,
    output logic signed [COORD_BITS:0]  o_corner1_y,
    output logic signed [COORD_BITS:0]  o_corner2_x,
    output logic signed [COORD_BITS:0]  o_corner2_y,
    output logic signed [COORD_BITS:0]  o_corner3_x,
    output logic signed [COORD_BITS:0]  o_corner3_y,
    input  logic                        i_cfg_we,
    input  logic [RANGE_BITS-1:0]       i_cfg_data
);

    localparam int CB     = COORD_BITS;
    localparam int RB     = RANGE_BITS;
    localparam int QW     = 2 * RB + 2 * FRAC_BITS;
    localparam int SQW    = RB + FRAC_BITS;
    localparam int SIDE_W = 6 * CB + 3;
    localparam int NW     = 2 * (RB + CB);
    localparam int DW     = 2 * CB + 1;

    logic [RB-1:0]       r_range;
    logic                en;

    logic                f_vld;
    logic [SIDE_W-1:0]   f_side;
    logic [NW-1:0]       f_n;
    logic [DW-1:0]       f_d;

    logic                d1_vld;
    logic [QW-1:0]       d1_quo;
    logic [SIDE_W-1:0]   d1_side;

    logic                s_vld;
    logic [SQW-1:0]      s_root;
    logic [SIDE_W-1:0]   s_side;

    logic                r_mid_vld;
    logic [CB+SQW-1:0]   r_mid_p;
    logic [RB:0]         r_mid_oxu;
    logic [SIDE_W-1:0]   r_mid_side;
    logic [SQW:0]        q_rnd;

    logic                d2_vld;
    logic [SQW-1:0]      d2_quo;
    logic [SIDE_W+RB:0]  d2_side;

    // Proximity range register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_range <= RB'(4);
        end else if (i_cfg_we) begin
            r_range <= i_cfg_data;
        end
    end

    // The whole pipeline moves unless a finished result is being held.
    assign o_stall = o_valid & i_stall;
    assign en      = ~o_stall;

    lsr_front #(.CB(CB)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (i_valid),
        .i_sx    (i_start_x),
        .i_sy    (i_start_y),
        .i_ex    (i_end_x),
        .i_ey    (i_end_y),
        .i_range (r_range),
        .o_vld   (f_vld),
        .o_side  (f_side),
        .o_n     (f_n),
        .o_d     (f_d)
    );

    // Squared offset quotient: (r*|dy|)^2 * 2^(2*FRAC_BITS) / (dx^2 + dy^2).
    lsr_div #(.W(DW), .QW(QW), .SW(SIDE_W)) u_div_len (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (f_vld),
        .i_rem   ({1'b0, f_n[NW-1:2*RB]}),
        .i_bits  ({f_n[2*RB-1:0], {(2*FRAC_BITS){1'b0}}}),
        .i_dvs   (f_d),
        .i_side  (f_side),
        .o_vld   (d1_vld),
        .o_quo   (d1_quo),
        .o_side  (d1_side)
    );

    lsr_sqrt #(.XW(QW), .SW(SIDE_W)) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (d1_vld),
        .i_x     (d1_quo),
        .i_side  (d1_side),
        .o_vld   (s_vld),
        .o_root  (s_root),
        .o_side  (s_side)
    );

    // Round the x offset and form |dx| times the unrounded offset.
    assign q_rnd = {1'b0, s_root} + ((SQW+1)'(1) << (FRAC_BITS-1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mid_vld <= 1'b0;
        end else if (en) begin
            r_mid_vld <= s_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_mid_p    <= {{SQW{1'b0}}, s_side[2*CB+2:CB+3]} * {{CB{1'b0}}, s_root};
            r_mid_oxu  <= q_rnd[SQW:FRAC_BITS];
            r_mid_side <= s_side;
        end
    end

    // Magnitude of the y offset: |dx| * offset / |dy|.
    lsr_div #(.W(CB), .QW(SQW), .SW(SIDE_W+RB+1)) u_div_slope (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (r_mid_vld),
        .i_rem   (r_mid_p[CB+SQW-1:SQW]),
        .i_bits  (r_mid_p[SQW-1:0]),
        .i_dvs   (r_mid_side[CB+2:3]),
        .i_side  ({r_mid_side, r_mid_oxu}),
        .o_vld   (d2_vld),
        .o_quo   (d2_quo),
        .o_side  (d2_side)
    );

    lsr_back #(.CB(CB), .FB(FRAC_BITS)) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (d2_vld),
        .i_side  (d2_side[SIDE_W+RB:RB+1]),
        .i_oxu   (d2_side[RB:0]),
        .i_m     (d2_quo),
        .i_range (r_range),
        .o_vld   (o_valid),
        .o_kind  (o_region_kind),
        .o_c0x   (o_corner0_x),
        .o_c0y   (o_corner0_y),
        .o_c1x   (o_corner1_x),
        .o_c1y   (o_corner1_y),
        .o_c2x   (o_corner2_x),
        .o_c2y   (o_corner2_y),
        .o_c3x   (o_corner3_x),
        .o_c3y   (o_corner3_y)
    );

endmodule

// ===== src/lsr_checker.sv =====
`include "assert_macros.svh"

module lsr_checker import lsr_pkg::*; #(
    parameter int CB = 16
) (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_stall,
    input logic                o_valid,
    input logic                i_stall,
    input logic [1:0]          o_region_kind,
    input logic signed [CB:0]  o_corner0_x,
    input logic signed [CB:0]  o_corner0_y,
    input logic signed [CB:0]  o_corner1_x,
    input logic signed [CB:0]  o_corner1_y,
    input logic signed [CB:0]  o_corner2_x,
    input logic signed [CB:0]  o_corner2_y,
    input logic signed [CB:0]  o_corner3_x,
    input logic signed [CB:0]  o_corner3_y
);

    logic [CB:0] off_start, off_end;
    logic        is_rect, rect_ok, is_slant;

    // Twice the offset, seen at the start and at the end of a slanted segment.
    assign off_start = o_corner0_x - o_corner1_x;
    assign off_end   = o_corner3_x - o_corner2_x;

    // Shape classes and the axis-aligned corner relation of a rectangle.
    assign is_rect  = o_region_kind inside {KIND_HORZ, KIND_VERT};
    assign is_slant = o_region_kind == KIND_SLANT;
    assign rect_ok  = o_corner0_y == o_corner1_y && o_corner2_y == o_corner3_y &&
                      o_corner0_x == o_corner3_x && o_corner1_x == o_corner2_x;

    // A held result stays valid.
    `AST_NEXT(a_out_hold, o_valid && i_stall, o_valid)

    // The input side stalls only behind a held result.
    `AST_IMPL(a_stall_cause, o_stall, o_valid && i_stall)

    // Rectangles are axis aligned.
    `AST_IMPL(a_rect_shape, o_valid && is_rect, rect_ok)

    // Both endpoints of a slanted segment move by the same x offset.
    `AST_IMPL(a_slant_offset, o_valid && is_slant, off_start == off_end)

endmodule

bind line_selection_region lsr_checker #(.CB(COORD_BITS)) u_lsr_checker (.*);
